// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a same-cycle implication at every clock edge outside reset.
`define KMG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition leads to another in the next cycle, outside reset.
`define KMG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_pkg
// Types and constants of the k-way merge group selector.
// ----------------------------------------------------------------------------
package kmg_pkg;
  localparam int NUM_SOURCES = 8;
  localparam int PER_SOURCE_DEPTH = 256;
  localparam int KEY_BITS = 64;
  localparam int VALUE_BITS = 64;
  localparam int SRC_W = $clog2(NUM_SOURCES);
  localparam int PTR_W = $clog2(PER_SOURCE_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int ADDR_W = SRC_W + PTR_W;
  localparam int MAX_SRC = (NUM_SOURCES < 8) ? NUM_SOURCES : 8;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_GROUP  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_GROUP   = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EXHAUST = 3'd3,
    ST_REFUSED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MARK_VALID  = 2'd0,
    MARK_REFILL = 2'd1,
    MARK_DRAIN  = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_FILL,
    S_FILLW,
    S_MIN,
    S_EMIT,
    S_OUT
  } fsm_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_APPEND,
    CMD_CLEAR,
    CMD_FILL_RD,
    CMD_FILL_WR,
    CMD_MIN,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [SRC_W-1:0] idx;
  } ctrl_t;

  typedef struct packed {
    logic             need_fill;
    logic             any_valid;
    logic             match;
    logic             last_match;
  } stat_t;

  localparam int REG_ACTIVE = 0;
  localparam int REG_KEYB = 1;
endpackage

// File: design/kway_merge_group_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_group_select
// K-way merge join over per-source record buffers.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in_*    | input     | in_valid / in_stall
// out_*   | output    | out_valid / out_stall
// p*      | APB       | psel / penable / pwrite
// An append or clear is taken in the idle state. A group item refills heads
// through the record memory port (a read step per source, a write step per
// refill), scans for the minimum, then emits the matching records. Reset is
// synchronous and needs no clearing pass. A stalled result holds the sequencer.
`include "assert_macros.svh"
module kway_merge_group_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_source,
  input  logic [63:0] in_record_key,
  input  logic [63:0] in_record_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_from_source,
  output logic [63:0] out_out_key,
  output logic [63:0] out_out_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kmg_pkg::*;

  logic [3:0] act_r;
  logic [3:0] kb_r;
  logic [3:0] eff_n;
  ctrl_t      ctrl;
  stat_t      stat;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 4'd8;
      kb_r <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(REG_ACTIVE) && paddr[1:0] == 2'b00) act_r <= pwdata[3:0];
      else if (paddr[2] == 1'(REG_KEYB) && paddr[1:0] == 2'b00) kb_r <= pwdata[3:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {28'd0, act_r};
    else if (paddr == 3'd4) prdata = {28'd0, kb_r};
  end

  kmg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .out_valid, .out_stall,
    .out_last, .eff_n, .stat, .ctrl
  );

  kmg_datapath u_dp (
    .clk, .rst_n, .ctrl, .stat, .in_source, .in_record_key,
    .in_record_value, .active_sources(act_r), .key_bytes(kb_r), .eff_n,
    .res_status(out_status), .res_source(out_from_source),
    .res_key(out_out_key), .res_value(out_out_value)
  );

  `KMG_ASSERT_IMP(a_key0, out_valid && out_status != ST_GROUP, out_out_key == '0, "stray key")
  `KMG_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `KMG_ASSERT_NXT(a_stable, out_valid && out_stall, $stable(out_out_value), "value changed")
endmodule

// File: design/kmg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_datapath
// Record memories, head registers, minimum search and result register.
// ----------------------------------------------------------------------------
module kmg_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kmg_pkg::ctrl_t              ctrl,
  output kmg_pkg::stat_t              stat,
  input  logic [2:0]                  in_source,
  input  logic [63:0]                 in_record_key,
  input  logic [63:0]                 in_record_value,
  input  logic [3:0]                  active_sources,
  input  logic [3:0]                  key_bytes,
  output logic [3:0]                  eff_n,
  output logic [2:0]                  res_status,
  output logic [2:0]                  res_source,
  output logic [63:0]                 res_key,
  output logic [63:0]                 res_value
);
  import kmg_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [NUM_SOURCES*PER_SOURCE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [NUM_SOURCES*PER_SOURCE_DEPTH];
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [CNT_W-1:0]      fill_r [NUM_SOURCES];
  logic [CNT_W-1:0]      cur_r [NUM_SOURCES];
  mark_t                 mark_r [NUM_SOURCES];
  logic [KEY_BITS-1:0]   hkey_r [NUM_SOURCES];
  logic [VALUE_BITS-1:0] hval_r [NUM_SOURCES];
  logic                  merging_r;
  logic [KEY_BITS-1:0]   min_r;
  logic                  minv_r;
  logic [2:0]            res_status_r;
  logic [2:0]            res_source_r;
  logic [63:0]           res_key_r;
  logic [63:0]           res_value_r;

  logic [3:0]            n_clip;
  logic [3:0]            kb;
  logic [6:0]            shamt;
  logic [SRC_W-1:0]      isrc;
  logic                  src_ok;
  logic [KEY_BITS-1:0]   cur_part;
  logic                  full;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;

  always_comb begin
    n_clip = active_sources;
    if (n_clip < 4'd1) n_clip = 4'd1;
    if (n_clip > 4'(MAX_SRC)) n_clip = 4'(MAX_SRC);
    kb = key_bytes;
    if (kb < 4'd1) kb = 4'd1;
    if (kb > 4'd8) kb = 4'd8;
    if ({kb, 3'b000} >= 7'(KEY_BITS)) shamt = 7'd0;
    else shamt = 7'(KEY_BITS) - {kb, 3'b000};
  end
  assign eff_n = n_clip;

  assign isrc = SRC_W'(in_source);
  assign src_ok = ({1'b0, in_source} < n_clip) && (32'(in_source) < NUM_SOURCES);
  assign full = fill_r[isrc] >= CNT_W'(PER_SOURCE_DEPTH);
  assign wr_en = (ctrl.cmd == CMD_APPEND) && !merging_r && src_ok && !full;
  assign wr_addr = {isrc, fill_r[isrc][PTR_W-1:0]};
  assign rd_addr = {ctrl.idx, cur_r[ctrl.idx][PTR_W-1:0]};
  assign cur_part = hkey_r[ctrl.idx] >> shamt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= in_record_key[KEY_BITS-1:0];
      val_mem[wr_addr] <= in_record_value[VALUE_BITS-1:0];
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  always_comb begin
    stat.need_fill = (mark_r[ctrl.idx] == MARK_REFILL) &&
                     (cur_r[ctrl.idx] < fill_r[ctrl.idx]);
    stat.any_valid = minv_r;
    stat.match = (mark_r[ctrl.idx] == MARK_VALID) && (cur_part == min_r);
    stat.last_match = 1'b1;
    for (int j = 0; j < NUM_SOURCES; j++) begin
      if (j > 32'(ctrl.idx) && j < 32'(n_clip) && mark_r[j] == MARK_VALID &&
          (hkey_r[j] >> shamt) == min_r) begin
        stat.last_match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.cmd == CMD_CLEAR) begin
      for (int j = 0; j < NUM_SOURCES; j++) begin
        fill_r[j] <= '0;
        cur_r[j]  <= '0;
        mark_r[j] <= MARK_REFILL;
        hkey_r[j] <= '0;
        hval_r[j] <= '0;
      end
      merging_r <= 1'b0;
      minv_r <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        CMD_APPEND: begin
          if (wr_en) fill_r[isrc] <= fill_r[isrc] + 1'b1;
        end
        CMD_FILL_RD: begin
          merging_r <= 1'b1;
          minv_r <= 1'b0;
          if (mark_r[ctrl.idx] == MARK_REFILL && cur_r[ctrl.idx] >= fill_r[ctrl.idx])
            mark_r[ctrl.idx] <= MARK_DRAIN;
        end
        CMD_FILL_WR: begin
          hkey_r[ctrl.idx] <= rd_key_r;
          hval_r[ctrl.idx] <= rd_val_r;
          cur_r[ctrl.idx] <= cur_r[ctrl.idx] + 1'b1;
          mark_r[ctrl.idx] <= MARK_VALID;
        end
        CMD_MIN: begin
          if (mark_r[ctrl.idx] == MARK_VALID && (!minv_r || cur_part < min_r)) begin
            min_r <= cur_part;
            minv_r <= 1'b1;
          end
        end
        CMD_EMIT: begin
          mark_r[ctrl.idx] <= MARK_REFILL;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_APPEND) begin
      res_source_r <= in_source;
      res_key_r <= '0;
      res_value_r <= '0;
      if (merging_r) res_status_r <= ST_REFUSED;
      else if (!src_ok || full) res_status_r <= ST_FULL;
      else res_status_r <= ST_ACCEPT;
    end else if (ctrl.cmd == CMD_EMIT) begin
      res_status_r <= ST_GROUP;
      res_source_r <= 3'(ctrl.idx);
      res_key_r <= 64'(hkey_r[ctrl.idx]);
      res_value_r <= 64'(hval_r[ctrl.idx]);
    end else if (ctrl.cmd == CMD_MIN && !minv_r && 32'(ctrl.idx) + 1 >= 32'(n_clip) &&
                 mark_r[ctrl.idx] != MARK_VALID) begin
      res_status_r <= ST_EXHAUST;
      res_source_r <= 3'd0;
      res_key_r <= '0;
      res_value_r <= '0;
    end
  end

  assign res_status = res_status_r;
  assign res_source = res_source_r;
  assign res_key = res_key_r;
  assign res_value = res_value_r;
endmodule

// File: design/kmg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_ctrl
// Sequencer for append, refill, minimum search and group emission.
// ----------------------------------------------------------------------------
module kmg_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_last,
  input  logic [3:0]                  eff_n,
  input  kmg_pkg::stat_t              stat,
  output kmg_pkg::ctrl_t              ctrl
);
  import kmg_pkg::*;

  fsm_t             state_r, state_nxt;
  logic [SRC_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic             last_r, last_nxt;
  logic             at_end;

  assign at_end = 32'(idx_r) + 1 >= 32'(eff_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      ov_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      ov_r <= ov_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    ov_nxt = ov_r && out_stall;
    last_nxt = last_r;
    ctrl.cmd = CMD_NOP;
    ctrl.idx = idx_r;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = ov_r;
        if (in_valid && !ov_r) begin
          unique case (action_t'(in_action))
            ACT_APPEND: begin
              ctrl.cmd = CMD_APPEND;
              ov_nxt = 1'b1;
              last_nxt = 1'b1;
            end
            ACT_GROUP: begin
              idx_nxt = '0;
              state_nxt = S_FILL;
            end
            ACT_CLEAR: ctrl.cmd = CMD_CLEAR;
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        ctrl.cmd = CMD_FILL_RD;
        if (stat.need_fill) state_nxt = S_FILLW;
        else if (at_end) begin
          idx_nxt = '0;
          state_nxt = S_MIN;
        end else idx_nxt = idx_r + 1'b1;
      end
      S_FILLW: begin
        ctrl.cmd = CMD_FILL_WR;
        if (at_end) begin
          idx_nxt = '0;
          state_nxt = S_MIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_FILL;
        end
      end
      S_MIN: begin
        if (!ov_r) begin
          ctrl.cmd = CMD_MIN;
          if (at_end) begin
            idx_nxt = '0;
            state_nxt = S_EMIT;
          end else idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!stat.any_valid) begin
          ov_nxt = 1'b1;
          last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (!ov_r || !out_stall) begin
          if (stat.match) begin
            ctrl.cmd = CMD_EMIT;
            ov_nxt = 1'b1;
            last_nxt = stat.last_match;
            if (stat.last_match) state_nxt = S_IDLE;
          end
          if (!at_end) idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_last = last_r;
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-way merge group selector. Appends fill the
// source buffers, group requests drain them in key order, and every result
// transfer is compared with a behavioral predictor of the merge. Register
// settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import kmg_pkg::*;

  localparam int DEPTH = PER_SOURCE_DEPTH;
  localparam int LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_NONE;
  logic [2:0]  in_source = '0;
  logic [63:0] in_record_key = '0;
  logic [63:0] in_record_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_from_source;
  logic [63:0] out_out_key;
  logic [63:0] out_out_value;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  kway_merge_group_select dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    status_t     status;
    logic [2:0]  src;
    logic [63:0] key;
    logic [63:0] value;
    logic        last;
  } merge_rec_t;

  typedef struct {
    action_t     act;
    logic [2:0]  src;
    logic [63:0] key;
    logic [63:0] value;
    logic        typed;
    status_t     exp_status;
  } stim_row_t;

  merge_rec_t  pending_q[$];
  logic [63:0] keys_m[NUM_SOURCES][DEPTH];
  logic [63:0] vals_m[NUM_SOURCES][DEPTH];
  int          fill_m[NUM_SOURCES];
  int          cursor_m[NUM_SOURCES];
  mark_t       mark_m[NUM_SOURCES];
  logic [63:0] hkey_m[NUM_SOURCES];
  logic [63:0] hval_m[NUM_SOURCES];
  logic        merging_m;
  logic [3:0]  active_reg = 4'd8;
  logic [3:0]  keyb_reg = 4'd8;
  status_t     last_pred = ST_GROUP;
  int          errors = 0;
  int          cycles = 0;
  int          sent = 0;
  int          received = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  function automatic logic [63:0] key_part(logic [63:0] k);
    int b;
    b = keyb_reg;
    if (b < 1) b = 1;
    if (b > 8) b = 8;
    if (b * 8 >= KEY_BITS) return k;
    return k >> (KEY_BITS - b * 8);
  endfunction

  task automatic clear_model();
    for (int s = 0; s < NUM_SOURCES; s++) begin
      fill_m[s] = 0;
      cursor_m[s] = 0;
      mark_m[s] = MARK_REFILL;
      hkey_m[s] = '0;
      hval_m[s] = '0;
    end
    merging_m = 1'b0;
  endtask

  task automatic push_rec(status_t st, logic [2:0] s, logic [63:0] k, logic [63:0] v);
    merge_rec_t r;
    r.status = st;
    r.src = s;
    r.key = k;
    r.value = v;
    r.last = 1'b1;
    pending_q.push_back(r);
    last_pred = st;
  endtask

  task automatic predict_merge(action_t act, logic [2:0] s, logic [63:0] k,
                               logic [63:0] v);
    int n;
    int minpos;
    n = active_reg;
    if (n < 1) n = 1;
    if (n > MAX_SRC) n = MAX_SRC;
    minpos = -1;
    case (act)
      ACT_APPEND: begin
        if (merging_m) push_rec(ST_REFUSED, s, '0, '0);
        else if (s >= n || fill_m[s] >= DEPTH) push_rec(ST_FULL, s, '0, '0);
        else begin
          keys_m[s][fill_m[s]] = k;
          vals_m[s][fill_m[s]] = v;
          fill_m[s]++;
          push_rec(ST_ACCEPT, s, '0, '0);
        end
      end
      ACT_CLEAR: clear_model();
      ACT_GROUP: begin
        merging_m = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (mark_m[i] == MARK_REFILL) begin
            if (cursor_m[i] < fill_m[i]) begin
              hkey_m[i] = keys_m[i][cursor_m[i]];
              hval_m[i] = vals_m[i][cursor_m[i]];
              cursor_m[i]++;
              mark_m[i] = MARK_VALID;
            end else begin
              mark_m[i] = MARK_DRAIN;
            end
          end
          if (mark_m[i] == MARK_VALID &&
              (minpos < 0 || key_part(hkey_m[i]) < key_part(hkey_m[minpos])))
            minpos = i;
        end
        if (minpos < 0) push_rec(ST_EXHAUST, '0, '0, '0);
        else begin
          for (int i = 0; i < n; i++) begin
            if (mark_m[i] == MARK_VALID &&
                key_part(hkey_m[i]) == key_part(hkey_m[minpos])) begin
              push_rec(ST_GROUP, i[2:0], hkey_m[i], hval_m[i]);
              pending_q[pending_q.size() - 1].last = 1'b0;
              mark_m[i] = MARK_REFILL;
            end
          end
          pending_q[pending_q.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(action_t act, logic [2:0] s, logic [63:0] k, logic [63:0] v);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    predict_merge(act, s, k, v);
    in_valid <= 1'b1;
    in_action <= act;
    in_source <= s;
    in_record_key <= k;
    in_record_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_wait();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_ACTIVE) active_reg = data[3:0];
    else keyb_reg = data[3:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer status %0d", out_status);
        errors++;
      end else begin
        merge_rec_t e;
        e = pending_q.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status); errors++;
        end
        if (out_from_source !== e.src) begin
          $error("from_source expected %0d actual %0d", e.src, out_from_source); errors++;
        end
        if (out_out_key !== e.key) begin
          $error("out_key expected %h actual %h", e.key, out_out_key); errors++;
        end
        if (out_out_value !== e.value) begin
          $error("out_value expected %h actual %h", e.value, out_out_value); errors++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  stim_row_t rows[] = '{
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b1, ST_EXHAUST},
    '{ACT_APPEND, 3'd0, 64'h0, 64'h0, 1'b1, ST_REFUSED},
    '{ACT_CLEAR,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP},
    '{ACT_APPEND, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_ACCEPT},
    '{ACT_APPEND, 3'd7, 64'h0, 64'h0, 1'b1, ST_ACCEPT},
    '{ACT_APPEND, 3'd3, 64'h0, 64'h1234, 1'b1, ST_ACCEPT},
    '{ACT_APPEND, 3'd5, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 1'b0, ST_GROUP},
    '{ACT_APPEND, 3'd1, 64'h0000_0000_0000_0001, 64'h1, 1'b0, ST_GROUP},
    '{ACT_NONE,   3'd2, 64'h1, 64'h1, 1'b0, ST_GROUP},
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP},
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP},
    '{ACT_APPEND, 3'd2, 64'h0, 64'h0, 1'b1, ST_REFUSED},
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP},
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP},
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP},
    '{ACT_GROUP,  3'd0, 64'h0, 64'h0, 1'b1, ST_EXHAUST},
    '{ACT_CLEAR,  3'd0, 64'h0, 64'h0, 1'b0, ST_GROUP}
  };

  task automatic random_phase(int count, int n_src);
    int r;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = {$urandom, $urandom};
      if ($urandom_range(1)) k[55:0] = 56'($urandom_range(3));
      if (!merging_m && r < 55)
        send_item(ACT_APPEND, 3'($urandom_range(n_src - 1)), k, {$urandom, $urandom});
      else if (r < 62)
        send_item(ACT_APPEND, 3'($urandom_range(7)), k, {$urandom, $urandom});
      else if (r < 93) send_item(ACT_GROUP, 3'($urandom_range(7)), k, k);
      else if (r < 97) send_item(ACT_CLEAR, '0, '0, '0);
      else send_item(ACT_NONE, 3'($urandom_range(7)), k, k);
    end
  endtask

  initial begin
    clear_model();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) begin
      send_item(rows[i].act, rows[i].src, rows[i].key, rows[i].value);
      if (rows[i].typed && last_pred != rows[i].exp_status) begin
        $error("status expected %0d actual %0d row %0d", rows[i].exp_status, last_pred, i);
        errors++;
      end
    end
    drain_wait();
    send_idle = 20; recv_idle = 61;
    write_reg(REG_ACTIVE, 32'd1); write_reg(REG_KEYB, 32'd1);
    random_phase(20, 2);
    drain_wait();
    write_reg(REG_ACTIVE, 32'd3); write_reg(REG_KEYB, 32'd0);
    send_item(ACT_CLEAR, '0, '0, '0);
    random_phase(20, 4);
    drain_wait();
    send_idle = 61; recv_idle = 20;
    write_reg(REG_ACTIVE, 32'd15); write_reg(REG_KEYB, 32'd15);
    send_item(ACT_CLEAR, '0, '0, '0);
    random_phase(20, 8);
    drain_wait();
    write_reg(REG_ACTIVE, 32'd0); write_reg(REG_KEYB, 32'd2);
    send_item(ACT_CLEAR, '0, '0, '0);
    random_phase(10, 1);
    drain_wait();
    send_idle = 0; recv_idle = 0;
    write_reg(REG_ACTIVE, 32'd8); write_reg(REG_KEYB, 32'd8);
    send_item(ACT_CLEAR, '0, '0, '0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(ACT_APPEND, 3'd6, 64'(i), 64'(~i));
    random_phase(10, 8);
    drain_wait();
    $display("Transferred %0d input items and checked %0d result transfers", sent, received);
    $display("over five register settings including both extremes and a full buffer.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
